// ----- rtl/dpp_pkg.sv -----
// shared types, constants and helper function of the depth pixel to point block
package dpp_pkg;

  localparam int DEPTH_BITS = 14;
  localparam int COORD_BITS = 12;
  localparam int COLOUR_W   = 8;
  localparam int NUM_W      = DEPTH_BITS + 32;  // dividend bits, one divider stage each
  localparam int DIV_W      = 44;               // divisor magnitude bits
  localparam int OFF_W      = COORD_BITS + 16 + 5;  // pixel position minus centre
  localparam int CFG_W      = 32;
  localparam int IDX_W      = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_OFFSET = 3'd2;
  localparam logic [IDX_W-1:0] REG_FOCAL  = 3'd3;
  localparam logic [IDX_W-1:0] REG_CX     = 3'd4;
  localparam logic [IDX_W-1:0] REG_CY     = 3'd5;
  localparam logic [IDX_W-1:0] REG_MAXD   = 3'd6;
  localparam logic [IDX_W-1:0] REG_SCALE  = 3'd7;

  // pixel formats
  localparam logic [1:0] FMT_DISP8   = 2'd0;
  localparam logic [1:0] FMT_DISP11  = 2'd1;
  localparam logic [1:0] FMT_DEPTH14 = 2'd2;
  localparam logic [1:0] FMT_NONE    = 2'd3;

  typedef struct packed {
    logic [DEPTH_BITS-1:0] depth_code;
    logic [COORD_BITS-1:0] pixel_column;
    logic [COORD_BITS-1:0] pixel_row;
    logic [COLOUR_W-1:0]   red_in;
    logic [COLOUR_W-1:0]   green_in;
    logic [COLOUR_W-1:0]   blue_in;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0]  x_pos;
    logic signed [31:0]  y_pos;
    logic signed [31:0]  z_pos;
    logic [COLOUR_W-1:0] red_out;
    logic [COLOUR_W-1:0] green_out;
    logic [COLOUR_W-1:0] blue_out;
  } point_t;

  typedef struct packed {
    logic [2:0]         pixel_mode;
    logic signed [31:0] disparity_gain;
    logic signed [31:0] disparity_offset;
    logic signed [31:0] focal_length;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [15:0]        max_depth;
    logic [30:0]        output_scale;
  } cfg_t;

  // per-pixel control and side data carried down the pipeline
  typedef struct packed {
    logic [1:0]              fmt;
    logic                    ok;
    logic                    neg;
    logic [DEPTH_BITS-1:0]   code;
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
    logic [COLOUR_W-1:0]     red;
    logic [COLOUR_W-1:0]     green;
    logic [COLOUR_W-1:0]     blue;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DIV_W-1:0] dvs;
    side_t            side;
  } div_in_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/dpp_front.sv -----
// front end: mode decode, disparity product and divider operand set-up
module dpp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  dpp_pkg::pixel_t  in_data,
  input  dpp_pkg::cfg_t    cfg,
  output logic             f_valid,
  output dpp_pkg::div_in_t f_data
);
  import dpp_pkg::*;

  localparam logic [NUM_W-1:0] NUM_DISP = NUM_W'(1) << 35;

  logic               v1;
  logic signed [43:0] prod1;
  side_t              side1;
  side_t              side1_next;
  logic [1:0]         fmt;
  logic               rng;

  always_comb begin
    unique case (cfg.pixel_mode)
      3'd0, 3'd3: fmt = FMT_DISP8;
      3'd1, 3'd4: fmt = FMT_DISP11;
      3'd2, 3'd5: fmt = FMT_DEPTH14;
      default:    fmt = FMT_NONE;
    endcase
    unique case (fmt)
      FMT_DISP8:   rng = (in_data.depth_code[DEPTH_BITS-1:8] == '0);
      FMT_DISP11:  rng = (in_data.depth_code[DEPTH_BITS-1:11] == '0);
      FMT_DEPTH14: rng = 1'b1;
      default:     rng = 1'b0;
    endcase
    side1_next.fmt   = fmt;
    side1_next.ok    = rng && (in_data.depth_code != '0);
    side1_next.neg   = 1'b0;
    side1_next.code  = in_data.depth_code;
    side1_next.off_x = $signed({{(OFF_W-COORD_BITS-16){1'b0}}, in_data.pixel_column, 16'b0})
                       - OFF_W'(cfg.center_x);
    side1_next.off_y = $signed({{(OFF_W-COORD_BITS-16){1'b0}}, in_data.pixel_row, 16'b0})
                       - OFF_W'(cfg.center_y);
    if (cfg.pixel_mode < 3'd3) begin
      side1_next.red   = in_data.red_in;
      side1_next.green = in_data.green_in;
      side1_next.blue  = in_data.blue_in;
    end else begin
      side1_next.red   = '0;
      side1_next.green = '1;
      side1_next.blue  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      side1 <= side1_next;
      prod1 <= cfg.disparity_gain * $signed({1'b0, in_data.depth_code[10:0]});
    end
  end

  // second stage: denominator and divider operands
  logic signed [47:0] prod_x;
  logic signed [47:0] offs_x;
  logic signed [47:0] den;
  logic [47:0]        den_mag;
  logic [31:0]        foc_mag;
  div_in_t            f_next;

  always_comb begin
    prod_x  = 48'(prod1);
    offs_x  = 48'(cfg.disparity_offset);
    den     = (side1.fmt == FMT_DISP8) ? ((prod_x + offs_x) <<< 3)
                                       : (prod_x + (offs_x <<< 3));
    den_mag = den[47] ? 48'(-den) : 48'(den);
    foc_mag = cfg.focal_length[31] ? 32'(-cfg.focal_length) : 32'(cfg.focal_length);
    f_next.side = side1;
    if (side1.fmt == FMT_DEPTH14) begin
      f_next.num      = {side1.code, 32'b0};
      f_next.dvs      = {{(DIV_W-32){1'b0}}, foc_mag};
      f_next.side.neg = cfg.focal_length[31];
    end else begin
      f_next.num      = NUM_DISP;
      f_next.dvs      = den_mag[DIV_W-1:0];
      f_next.side.neg = den[47];
    end
    f_next.side.ok = side1.ok && (f_next.dvs != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= v1;
    end
    if (en) begin
      f_data <= f_next;
    end
  end

endmodule

// ----- rtl/dpp_divider.sv -----
// pipelined restoring divider, one quotient bit per stage
module dpp_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      d_valid,
  input  dpp_pkg::div_in_t          d_data,
  output logic                      q_valid,
  output logic [dpp_pkg::NUM_W-1:0] q,
  output dpp_pkg::side_t            q_side
);
  import dpp_pkg::*;

  logic             v   [NUM_W];
  logic [DIV_W-1:0] rem [NUM_W];
  logic [NUM_W-1:0] quo [NUM_W];
  logic [NUM_W-1:0] numr[NUM_W];
  logic [DIV_W-1:0] dvs [NUM_W];
  side_t            side[NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             pv;
    logic [DIV_W-1:0] prem;
    logic [NUM_W-1:0] pquo;
    logic [NUM_W-1:0] pnum;
    logic [DIV_W-1:0] pdvs;
    side_t            pside;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign pv    = d_valid;
      assign prem  = '0;
      assign pquo  = '0;
      assign pnum  = d_data.num;
      assign pdvs  = d_data.dvs;
      assign pside = d_data.side;
    end else begin : g_next
      assign pv    = v[k-1];
      assign prem  = rem[k-1];
      assign pquo  = quo[k-1];
      assign pnum  = numr[k-1];
      assign pdvs  = dvs[k-1];
      assign pside = side[k-1];
    end

    assign trial = {prem, pnum[NUM_W-1]};
    assign diff  = trial - {1'b0, pdvs};
    assign ge    = (trial >= {1'b0, pdvs});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= pv;
      end
      if (en) begin
        rem[k]  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        quo[k]  <= {pquo[NUM_W-2:0], ge};
        numr[k] <= {pnum[NUM_W-2:0], 1'b0};
        dvs[k]  <= pdvs;
        side[k] <= pside;
      end
    end
  end

  assign q_valid = v[NUM_W-1];
  assign q       = quo[NUM_W-1];
  assign q_side  = side[NUM_W-1];

endmodule

// ----- rtl/dpp_back.sv -----
// back end: w saturation, depth, scaling and x/y products
module dpp_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  dpp_pkg::cfg_t             cfg,
  input  logic                      q_valid,
  input  logic [dpp_pkg::NUM_W-1:0] q,
  input  dpp_pkg::side_t            q_side,
  output logic                      out_valid,
  output dpp_pkg::point_t           out_data
);
  import dpp_pkg::*;

  // stage c: signed, saturated w
  logic               vc;
  side_t              sidec;
  side_t              sidec_next;
  logic signed [31:0] wc;
  logic signed [31:0] w_next;
  logic               big;
  logic               over_neg;

  always_comb begin
    big      = (q[NUM_W-1:31] != '0);
    over_neg = big && ((q[NUM_W-1:32] != '0) || (q[30:0] != '0));
    if (q_side.neg) w_next = over_neg ? 32'sh80000000 : $signed(-q[31:0]);
    else            w_next = big ? 32'sh7fffffff : $signed(q[31:0]);
    sidec_next    = q_side;
    sidec_next.ok = q_side.ok && (q != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= q_valid;
    end
    if (en) begin
      wc    <= w_next;
      sidec <= sidec_next;
    end
  end

  // stage d: focal*w and w*scale
  logic               vd;
  side_t              sided;
  logic               wpos_d;
  logic signed [63:0] fz_d;
  logic signed [63:0] pws_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vc;
    end
    if (en) begin
      sided  <= sidec;
      wpos_d <= !wc[31] && (wc != '0);
      fz_d   <= cfg.focal_length * wc;
      pws_d  <= wc * $signed({1'b0, cfg.output_scale});
    end
  end

  // stage e: depth, depth limit, saturation
  logic               ve;
  side_t              sidee;
  side_t              sidee_next;
  logic signed [31:0] zsat_e;
  logic signed [31:0] ws_e;
  logic signed [47:0] z;
  logic               disp;

  always_comb begin
    disp = (sided.fmt == FMT_DISP8) || (sided.fmt == FMT_DISP11);
    if (!disp)       z = $signed({{(32-DEPTH_BITS){1'b0}}, sided.code, 16'b0});
    else if (wpos_d) z = 48'(fz_d >>> 16);
    else             z = '0;
    sidee_next    = sided;
    sidee_next.ok = sided.ok && (z <= $signed({1'b0, cfg.max_depth, 16'b0}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= vd;
    end
    if (en) begin
      sidee  <= sidee_next;
      zsat_e <= sat32(66'(z));
      ws_e   <= sat32(66'(pws_d >>> 16));
    end
  end

  // stage f: final products
  logic               vf;
  side_t              sidef;
  logic signed [63:0] pz_f;
  logic signed [64:0] px_f;
  logic signed [64:0] py_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= ve;
    end
    if (en) begin
      sidef <= sidee;
      pz_f  <= zsat_e * $signed({1'b0, cfg.output_scale});
      px_f  <= ws_e * sidee.off_x;
      py_f  <= ws_e * sidee.off_y;
    end
  end

  // output register
  point_t out_next;

  always_comb begin
    if (sidef.ok) begin
      out_next.x_pos = sat32(66'(px_f >>> 16));
      out_next.y_pos = sat32(66'(py_f >>> 16));
      out_next.z_pos = sat32(66'(pz_f >>> 16));
    end else begin
      out_next.x_pos = '0;
      out_next.y_pos = '0;
      out_next.z_pos = '0;
    end
    out_next.red_out   = sidef.red;
    out_next.green_out = sidef.green;
    out_next.blue_out  = sidef.blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vf;
    end
    if (en) begin
      out_data <= out_next;
    end
  end

endmodule

// ----- rtl/depth_pixel_to_point.sv -----
// top level of the depth pixel to point reprojection block
// Reprojects one depth pixel per clock, unless stalled, into a coloured Q16.16 point. The pipeline
// takes a new pixel every cycle while not stalled: two front stages form the disparity denominator,
// a 46-stage restoring divider produces one quotient bit per stage, and five back stages saturate
// W, form Z, scale and build x and y. The whole pipeline freezes while a finished point waits under
// out_stall, so in_stall follows that condition in the same cycle.
// Registers are written through cfg_we/cfg_index/cfg_data and should change only while idle.
module depth_pixel_to_point (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dpp_pkg::pixel_t                 in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dpp_pkg::point_t                 out_data,
  input  logic                            cfg_we,
  input  logic [dpp_pkg::IDX_W-1:0]       cfg_index,
  input  logic [dpp_pkg::CFG_W-1:0]       cfg_data
);
  import dpp_pkg::*;

  cfg_t    cfg;
  logic    en;
  logic    f_valid;
  div_in_t f_data;
  logic    q_valid;
  logic [NUM_W-1:0] q;
  side_t   q_side;

  // the pipeline moves unless a finished point is held back
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_mode       <= 3'd1;
      cfg.disparity_gain   <= 32'sd65536;
      cfg.disparity_offset <= '0;
      cfg.focal_length     <= 32'sd65536;
      cfg.center_x         <= '0;
      cfg.center_y         <= '0;
      cfg.max_depth        <= 16'hffff;
      cfg.output_scale     <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   cfg.pixel_mode       <= cfg_data[2:0];
        REG_GAIN:   cfg.disparity_gain   <= $signed(cfg_data);
        REG_OFFSET: cfg.disparity_offset <= $signed(cfg_data);
        REG_FOCAL:  cfg.focal_length     <= $signed(cfg_data);
        REG_CX:     cfg.center_x         <= $signed(cfg_data);
        REG_CY:     cfg.center_y         <= $signed(cfg_data);
        REG_MAXD:   cfg.max_depth        <= cfg_data[15:0];
        REG_SCALE:  cfg.output_scale     <= cfg_data[30:0];
        default:    ;
      endcase
    end
  end

  // mode decode, disparity product, divider operands
  dpp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cfg      (cfg),
    .f_valid  (f_valid),
    .f_data   (f_data)
  );

  // reciprocal of the denominator, or depth over focal length
  dpp_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .d_valid (f_valid),
    .d_data  (f_data),
    .q_valid (q_valid),
    .q       (q),
    .q_side  (q_side)
  );

  // saturation, depth limit, scaling and coordinates
  dpp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q         (q),
    .q_side    (q_side),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // a held point stays on the output unchanged
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("output point changed during stall");

  // a held point freezes the divider as well
  a_div_frozen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(q_valid) && $stable(q))
    else $error("divider moved during output stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !q_valid && !f_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule
